// ===== rtl/nrle_pkg.sv =====
// Shared types, constants and helper functions for the note ring LED encoder.
package nrle_pkg;

  localparam int LANES = 4;

  // Palette fixed-point divide by 100: x * 5243 >> 19 is exact for x <= 10000.
  localparam logic [12:0] DIV100_RECIP = 13'd5243;
  localparam int DIV100_SHIFT = 19;

  localparam logic [6:0] BRIGHT_MAX   = 7'd100;
  localparam logic [6:0] BRIGHT_RESET = 7'd10;
  localparam logic [3:0] NOTE_MAX     = 4'd12;

  localparam logic [1:0] CH_GREEN = 2'd0;
  localparam logic [1:0] CH_RED   = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  typedef struct packed {
    logic [6:0] r;
    logic [6:0] g;
    logic [6:0] b;
  } lvl_t;

  typedef struct packed {
    logic act;
    lvl_t lvl;
  } lane_t;

  typedef struct packed {
    logic [2:0]       cnt;
    lvl_t [LANES-1:0] slot;
  } item_t;

  typedef struct packed {
    logic [3:0]  led_index;
    logic [1:0]  color_channel;
    logic [6:0]  level;
    logic [31:0] pulse_pattern;
    logic        last;
  } res_t;

  function automatic lvl_t nrle_palette(input logic [3:0] code);
    lvl_t p;
    case (code)
      4'd1:    p = '{r: 7'd100, g: 7'd0,   b: 7'd0};
      4'd2:    p = '{r: 7'd90,  g: 7'd10,  b: 7'd0};
      4'd3:    p = '{r: 7'd70,  g: 7'd30,  b: 7'd0};
      4'd4:    p = '{r: 7'd65,  g: 7'd25,  b: 7'd10};
      4'd5:    p = '{r: 7'd33,  g: 7'd33,  b: 7'd33};
      4'd6:    p = '{r: 7'd0,   g: 7'd100, b: 7'd0};
      4'd7:    p = '{r: 7'd15,  g: 7'd80,  b: 7'd15};
      4'd8:    p = '{r: 7'd8,   g: 7'd47,  b: 7'd44};
      4'd9:    p = '{r: 7'd7,   g: 7'd8,   b: 7'd85};
      4'd10:   p = '{r: 7'd0,   g: 7'd0,   b: 7'd100};
      4'd11:   p = '{r: 7'd50,  g: 7'd0,   b: 7'd50};
      4'd12:   p = '{r: 7'd85,  g: 7'd0,   b: 7'd15};
      default: p = '{r: 7'd0,   g: 7'd0,   b: 7'd0};
    endcase
    return p;
  endfunction

  // Each data bit becomes four samples 1, bit, 0, 0, MSB first.
  function automatic logic [31:0] nrle_pulse(input logic [6:0] level);
    logic [7:0]  v;
    logic [31:0] pat;
    v = {1'b0, level};
    for (int k = 0; k < 8; k++) begin
      pat[4*k +: 4] = {1'b1, v[k], 2'b00};
    end
    return pat;
  endfunction

endpackage

// ===== rtl/nrle_if.sv =====
// Valid/ready channel interfaces for the note word and the pulse result word.
interface nrle_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] note_first;
  logic [3:0] note_second;
  logic [3:0] note_third;
  logic [3:0] note_fourth;

  modport source (output valid, note_first, note_second, note_third, note_fourth,
                  input ready);
  modport sink (input valid, note_first, note_second, note_third, note_fourth,
                output ready);
endinterface

interface nrle_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  led_index;
  logic [1:0]  color_channel;
  logic [6:0]  level;
  logic [31:0] pulse_pattern;
  logic        last;

  modport source (output valid, led_index, color_channel, level, pulse_pattern, last,
                  input ready);
  modport sink (input valid, led_index, color_channel, level, pulse_pattern, last,
                output ready);
endinterface

// ===== rtl/nrle_lane.sv =====
// One note lane: palette lookup, brightness multiply, then divide by 100.
module nrle_lane
  import nrle_pkg::*;
(
  input  logic       clk,
  input  logic       en1,
  input  logic       en2,
  input  logic [3:0] code,
  input  logic [6:0] bright,
  output lane_t      lane_o
);

  lvl_t        pal;
  logic        act_r;
  logic [13:0] prod_r_r, prod_g_r, prod_b_r;
  logic [26:0] q_r, q_g, q_b;
  lane_t       lane_r;

  assign pal = nrle_palette(code);

  always_ff @(posedge clk) begin
    if (en1) begin
      act_r    <= (code != 4'd0) && (code <= NOTE_MAX);
      prod_r_r <= 14'(bright) * 14'(pal.r);
      prod_g_r <= 14'(bright) * 14'(pal.g);
      prod_b_r <= 14'(bright) * 14'(pal.b);
    end
  end

  assign q_r = 27'(prod_r_r) * 27'(DIV100_RECIP);
  assign q_g = 27'(prod_g_r) * 27'(DIV100_RECIP);
  assign q_b = 27'(prod_b_r) * 27'(DIV100_RECIP);

  always_ff @(posedge clk) begin
    if (en2) begin
      lane_r.act   <= act_r;
      lane_r.lvl.r <= q_r[DIV100_SHIFT +: 7];
      lane_r.lvl.g <= q_g[DIV100_SHIFT +: 7];
      lane_r.lvl.b <= q_b[DIV100_SHIFT +: 7];
    end
  end

  assign lane_o = lane_r;

endmodule

// ===== rtl/nrle_merge.sv =====
// Compacts the active lanes in order and counts them.
module nrle_merge
  import nrle_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  lane_t [LANES-1:0] lanes,
  output item_t             item_o
);

  item_t item_nxt;
  item_t item_r;

  always_comb begin
    item_nxt = '0;
    for (int k = 0; k < LANES; k++) begin
      if (lanes[k].act) begin
        item_nxt.slot[item_nxt.cnt[1:0]] = lanes[k].lvl;
        item_nxt.cnt = item_nxt.cnt + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= item_nxt;
    end
  end

  assign item_o = item_r;

endmodule

// ===== rtl/nrle_emit.sv =====
// Walks the ring LED by LED and channel by channel into the output register.
module nrle_emit
  import nrle_pkg::*;
#(
  parameter int LED_COUNT = 12
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  item_v,
  input  item_t item,
  output logic  take,
  input  logic  res_ready,
  output logic  res_valid,
  output res_t  res
);

  localparam int LED_W = $clog2(LED_COUNT);
  localparam int ACC_W = $clog2(LED_COUNT + LANES + 1);

  logic             busy_r, busy_nxt;
  logic             vld_r, vld_nxt;
  item_t            cur_r;
  logic [LED_W-1:0] led_r, led_nxt;
  logic [1:0]       ch_r, ch_nxt;
  logic [1:0]       seg_r, seg_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt, acc_sum;
  res_t             res_r, res_nxt;
  logic             gen, is_last;
  lvl_t             lv;
  logic [6:0]       level;

  assign gen     = busy_r && (!vld_r || res_ready);
  assign is_last = (led_r == LED_W'(LED_COUNT - 1)) && (ch_r == CH_BLUE);
  assign take    = item_v && (!busy_r || (gen && is_last));

  assign lv      = (cur_r.cnt == 3'd0) ? '0 : cur_r.slot[seg_r];
  assign acc_sum = acc_r + ACC_W'(cur_r.cnt);

  always_comb begin
    case (ch_r)
      CH_GREEN: level = lv.g;
      CH_RED:   level = lv.r;
      CH_BLUE:  level = lv.b;
      default:  level = 7'd0;
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    vld_nxt  = vld_r && !res_ready;
    led_nxt  = led_r;
    ch_nxt   = ch_r;
    seg_nxt  = seg_r;
    acc_nxt  = acc_r;
    res_nxt  = res_r;
    if (gen) begin
      vld_nxt               = 1'b1;
      res_nxt.led_index     = 4'(led_r);
      res_nxt.color_channel = ch_r;
      res_nxt.level         = level;
      res_nxt.pulse_pattern = nrle_pulse(level);
      res_nxt.last          = is_last;
      if (ch_r == CH_BLUE) begin
        ch_nxt  = CH_GREEN;
        led_nxt = led_r + LED_W'(1);
        // segment = floor(led * n / LED_COUNT), tracked by remainder
        if (acc_sum >= ACC_W'(LED_COUNT)) begin
          acc_nxt = acc_sum - ACC_W'(LED_COUNT);
          seg_nxt = seg_r + 2'd1;
        end else begin
          acc_nxt = acc_sum;
        end
      end else begin
        ch_nxt = ch_r + 2'd1;
      end
      if (is_last) begin
        busy_nxt = 1'b0;
      end
    end
    if (take) begin
      busy_nxt = 1'b1;
      led_nxt  = '0;
      ch_nxt   = CH_GREEN;
      seg_nxt  = 2'd0;
      acc_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      vld_r  <= 1'b0;
      led_r  <= '0;
      ch_r   <= CH_GREEN;
      seg_r  <= 2'd0;
      acc_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      vld_r  <= vld_nxt;
      led_r  <= led_nxt;
      ch_r   <= ch_nxt;
      seg_r  <= seg_nxt;
      acc_r  <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (take) begin
      cur_r <= item;
    end
  end

  assign res_valid = vld_r;
  assign res       = res_r;

endmodule

// ===== rtl/note_ring_led_pulse_encoder.sv =====
// Note ring LED pulse encoder: top level.
//
// Input channel in_ch carries four note codes per word (0 or 13-15 silent,
// 1-12 pitch classes). Output channel out_ch carries 3*LED_COUNT words per
// input word: for each LED in ring order, green, red and blue levels with
// their 32-bit pulse patterns; last marks the final blue word.
// cfg_we/cfg_wdata write the brightness percent, clamped to 100.
//
// Four lanes scale the palette of each note (multiply, then divide by 100
// through a reciprocal multiply), a merge stage compacts the active notes,
// and a sequencer walks the ring into the output register.
// Path: lane product, lane level, merge, item and output registers.
// Throughput: one result word per cycle while out_ch.ready is high; the
// output sequencer sets this rate, one input word per 3*LED_COUNT words.
// A new input word is taken while earlier ones are still in flight.
// Reset clears all valid flags and loads brightness 10. When out_ch.ready is
// low the output word holds and the pipeline stalls behind it.
module note_ring_led_pulse_encoder
  import nrle_pkg::*;
#(
  parameter int LED_COUNT = 12
) (
  input  logic       clk,
  input  logic       rst_n,
  nrle_in_if.sink    in_ch,
  nrle_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic [6:0] cfg_wdata
);

  logic              s1_v_r, s2_v_r, s3_v_r;
  logic              adv1, adv2, adv3, take;
  logic [6:0]        bright_r;
  logic [3:0]        codes [LANES];
  lane_t [LANES-1:0] lanes;
  item_t             item;
  logic              res_valid;
  res_t              res;

  assign codes[0] = in_ch.note_first;
  assign codes[1] = in_ch.note_second;
  assign codes[2] = in_ch.note_third;
  assign codes[3] = in_ch.note_fourth;

  assign adv3        = s2_v_r && (!s3_v_r || take);
  assign adv2        = s1_v_r && (!s2_v_r || adv3);
  assign in_ch.ready = !s1_v_r || adv2;
  assign adv1        = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bright_r <= BRIGHT_RESET;
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      s3_v_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        bright_r <= (cfg_wdata > BRIGHT_MAX) ? BRIGHT_MAX : cfg_wdata;
      end
      if (in_ch.ready) s1_v_r <= adv1;
      if (!s2_v_r || adv3) s2_v_r <= adv2;
      if (!s3_v_r || take) s3_v_r <= adv3;
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    nrle_lane u_lane (
      .clk    (clk),
      .en1    (adv1),
      .en2    (adv2),
      .code   (codes[g]),
      .bright (bright_r),
      .lane_o (lanes[g])
    );
  end

  nrle_merge u_merge (
    .clk    (clk),
    .en     (adv3),
    .lanes  (lanes),
    .item_o (item)
  );

  nrle_emit #(
    .LED_COUNT (LED_COUNT)
  ) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_v    (s3_v_r),
    .item      (item),
    .take      (take),
    .res_ready (out_ch.ready),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_ch.valid         = res_valid;
  assign out_ch.led_index     = res.led_index;
  assign out_ch.color_channel = res.color_channel;
  assign out_ch.level         = res.level;
  assign out_ch.pulse_pattern = res.pulse_pattern;
  assign out_ch.last          = res.last;

endmodule

// ===== rtl/nrle_checker.sv =====
// Port-level assertions for the note ring LED encoder, bound to the top level.
module nrle_checker
  import nrle_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_color_channel,
  input logic [6:0]  out_level,
  input logic [31:0] out_pulse_pattern,
  input logic        out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_last_blue: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_color_channel == CH_BLUE)
    else $error("last flag on a non-blue word");

  a_pulse_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pulse_pattern[31:28] == 4'b1000 &&
                  out_pulse_pattern[2] == out_level[0] &&
                  out_pulse_pattern[26] == out_level[6])
    else $error("pulse pattern does not match level");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind note_ring_led_pulse_encoder nrle_checker u_nrle_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_color_channel (out_ch.color_channel),
  .out_level         (out_ch.level),
  .out_pulse_pattern (out_ch.pulse_pattern),
  .out_last          (out_ch.last)
);

// ===== sim/tb_top.sv =====
// Self-checking testbench for the note ring LED pulse encoder.
`timescale 1ns / 100ps

module tb_top
  import nrle_pkg::*;
();

  localparam int RING = 12;

  // palette percentages for note codes 1..12, split by channel
  localparam int RED_PCT   [12] = '{100, 90, 70, 65, 33, 0, 15, 8, 7, 0, 50, 85};
  localparam int GREEN_PCT [12] = '{0, 10, 30, 25, 33, 100, 80, 47, 8, 0, 0, 0};
  localparam int BLUE_PCT  [12] = '{0, 0, 0, 10, 33, 0, 15, 44, 85, 100, 50, 15};

  localparam logic [1:0] CHANNEL_ORDER [3] = '{CH_GREEN, CH_RED, CH_BLUE};

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [6:0] cfg_wdata;

  nrle_in_if  in_ch ();
  nrle_out_if out_ch ();

  note_ring_led_pulse_encoder #(
    .LED_COUNT(RING)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  int unsigned brightness_pct;
  res_t        expected_words[$];
  int          err_count;
  bit          in_burst;
  bit          out_burst;
  int          out_hold;

  always #5 clk = ~clk;

  function automatic logic [31:0] pulse_word(input logic [7:0] lv);
    logic [31:0] pat;
    pat = '0;
    for (int b = 7; b >= 0; b--) begin
      pat = {pat[27:0], 1'b1, lv[b], 2'b00};
    end
    return pat;
  endfunction

  // Expected 36 words for one chord at the current brightness.
  task automatic encode_ring(input logic [3:0] a, input logic [3:0] b,
                             input logic [3:0] c, input logic [3:0] d);
    logic [3:0] codes [4];
    logic [3:0] active [4];
    int         n;
    int         seg;
    int         pal;
    int         pct [3];
    logic [6:0] lvl;
    res_t       w;
    codes = '{a, b, c, d};
    n = 0;
    for (int k = 0; k < 4; k++) begin
      if (codes[k] != 4'd0 && codes[k] <= NOTE_MAX) begin
        active[n] = codes[k];
        n++;
      end
    end
    for (int led = 0; led < RING; led++) begin
      pct = '{0, 0, 0};
      if (n != 0) begin
        seg = (led * n) / RING;
        pal = int'(active[seg]) - 1;
        pct = '{GREEN_PCT[pal], RED_PCT[pal], BLUE_PCT[pal]};
      end
      for (int ch = 0; ch < 3; ch++) begin
        lvl = 7'((brightness_pct * pct[ch]) / 100);
        w.led_index     = 4'(led);
        w.color_channel = CHANNEL_ORDER[ch];
        w.level         = lvl;
        w.pulse_pattern = pulse_word({1'b0, lvl});
        w.last          = (led == RING - 1) && (CHANNEL_ORDER[ch] == CH_BLUE);
        expected_words.push_back(w);
      end
    end
  endtask

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
  endtask

  // Valid stays high across back-to-back chords: only one assignment per step.
  task automatic send_chord(input logic [3:0] a, input logic [3:0] b,
                            input logic [3:0] c, input logic [3:0] d);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.note_first  <= a;
    in_ch.note_second <= b;
    in_ch.note_third  <= c;
    in_ch.note_fourth <= d;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    encode_ring(a, b, c, d);
  endtask

  task automatic drain_and_settle();
    in_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_brightness(input logic [6:0] v);
    drain_and_settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    brightness_pct = (v > BRIGHT_MAX) ? int'(BRIGHT_MAX) : int'(v);
  endtask

  function automatic logic [3:0] random_code();
    int r;
    r = $urandom_range(0, 19);
    if (r < 7) return 4'd0;
    if (r < 18) return 4'($urandom_range(1, 12));
    return 4'($urandom_range(13, 15));
  endfunction

  // result side: check each accepted word against the oldest expectation, then a random stall unless out_burst
  always @(posedge clk) begin : result_side
    res_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_words.size() == 0) begin
          report($sformatf("word led %0d ch %0d with nothing expected",
                           out_ch.led_index, out_ch.color_channel));
        end else begin
          want = expected_words.pop_front();
          check_field("led_index", 32'(out_ch.led_index), 32'(want.led_index));
          check_field("color_channel", 32'(out_ch.color_channel),
                      32'(want.color_channel));
          check_field("level", 32'(out_ch.level), 32'(want.level));
          check_field("pulse_pattern", out_ch.pulse_pattern, want.pulse_pattern);
          check_field("last", 32'(out_ch.last), 32'(want.last));
        end
        out_hold = out_burst ? 0 : $urandom_range(0, 11);
      end else if (out_hold > 0) begin
        out_hold--;
      end
      out_ch.ready <= (out_hold == 0);
    end
  end

  task automatic test_default_brightness();
    send_chord(4'd0, 4'd0, 4'd0, 4'd0);
    send_chord(4'd1, 4'd2, 4'd3, 4'd4);
    send_chord(4'd10, 4'd0, 4'd0, 4'd0);
  endtask

  task automatic test_full_palette();
    write_brightness(BRIGHT_MAX);
    send_chord(4'd1, 4'd2, 4'd3, 4'd4);
    send_chord(4'd5, 4'd6, 4'd7, 4'd8);
    send_chord(4'd9, 4'd10, 4'd11, 4'd12);
    send_chord(4'd0, 4'd0, 4'd0, 4'd6);
    send_chord(4'd7, 4'd0, 4'd0, 4'd0);
    send_chord(4'd0, 4'd3, 4'd0, 4'd11);
    // out-of-range codes drop out like silence
    send_chord(4'd13, 4'd14, 4'd15, 4'd0);
    send_chord(4'd15, 4'd2, 4'd14, 4'd9);
    send_chord(4'd4, 4'd13, 4'd8, 4'd12);
    send_chord(4'd15, 4'd15, 4'd15, 4'd15);
    send_chord(4'd12, 4'd0, 4'd12, 4'd0);
  endtask

  task automatic test_brightness_limits();
    write_brightness(7'd127);
    send_chord(4'd5, 4'd9, 4'd0, 4'd0);
    write_brightness(7'd101);
    send_chord(4'd6, 4'd10, 4'd1, 4'd0);
    write_brightness(7'd0);
    send_chord(4'd1, 4'd2, 4'd3, 4'd4);
    send_chord(4'd8, 4'd8, 4'd8, 4'd8);
    write_brightness(7'd1);
    send_chord(4'd5, 4'd5, 4'd5, 4'd5);
    write_brightness(7'd99);
    send_chord(4'd7, 4'd3, 4'd11, 4'd2);
  endtask

  task automatic test_random_chords();
    for (int phase = 0; phase < 6; phase++) begin
      write_brightness(7'($urandom_range(0, 127)));
      in_burst  = (phase % 4 == 1);
      out_burst = (phase % 4 == 2);
      for (int k = 0; k < 60; k++) begin
        // occasional stretches with no idling on either side
        if ($urandom_range(0, 15) == 0) in_burst = ~in_burst;
        if ($urandom_range(0, 15) == 0) out_burst = ~out_burst;
        send_chord(random_code(), random_code(), random_code(), random_code());
      end
    end
  endtask

  initial begin
    err_count          = 0;
    brightness_pct     = int'(BRIGHT_RESET);
    in_burst           = 1'b0;
    out_burst          = 1'b0;
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.note_first  <= '0;
    in_ch.note_second <= '0;
    in_ch.note_third  <= '0;
    in_ch.note_fourth <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_brightness();
    test_full_palette();
    test_brightness_limits();
    test_random_chords();

    drain_and_settle();
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/nrle_pkg.sv
rtl/nrle_if.sv
rtl/nrle_lane.sv
rtl/nrle_merge.sv
rtl/nrle_emit.sv
rtl/note_ring_led_pulse_encoder.sv
rtl/nrle_checker.sv
sim/tb_top.sv
